[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, reset by rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HPS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hps_pkg.sv]
// ---------------------------------------------------------------------------
// hps_pkg
// Types and constants of the hypercube permutation scorer.
// ---------------------------------------------------------------------------
package hps_pkg;

    localparam int NODES    = 8;
    localparam int DIMS     = 3;
    localparam int PKT_W    = 4;
    localparam int NODE_W   = 3;
    localparam int NODE_CW  = NODE_W + 1;
    localparam int WORD_W   = 32;
    localparam int STATE_W  = NODES * PKT_W;
    localparam int NUM_DIMS = 3;

    localparam logic [NODE_W-1:0]  DIM_MASK  = NODE_W'((1 << DIMS) - 1);
    localparam logic [NODE_CW-1:0] NODES_CNT = NODE_CW'(NODES);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_SWAP = 1'b1;

    typedef struct packed {
        logic              action;
        logic [WORD_W-1:0] load_word;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } hps_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] packed_state;
        logic              solved;
        logic [4:0]        distance_sum;
        logic [3:0]        misplaced;
        logic [1:0]        worst_distance;
        logic [4:0]        dim0_score;
        logic [4:0]        dim1_score;
        logic [4:0]        dim2_score;
        logic              pair_is_edge;
    } hps_result_t;

endpackage

[hw/rtl/hps_state.sv]
// ---------------------------------------------------------------------------
// hps_state
// Packet-per-node register file with load and swap update.
// ---------------------------------------------------------------------------
module hps_state import hps_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_en,
    input  hps_item_t          item,
    output logic [STATE_W-1:0] state_next
);

    logic [STATE_W-1:0] state_reg;
    logic [PKT_W-1:0]   pkt_a;
    logic [PKT_W-1:0]   pkt_b;
    logic               swap_ok;

    always_comb
    begin
        swap_ok = (item.action == ACT_SWAP)
                  && ({1'b0, item.node_a} < NODES_CNT)
                  && ({1'b0, item.node_b} < NODES_CNT);
        pkt_a = '0;
        pkt_b = '0;
        for (int j = 0; j < NODES; j++)
        begin
            if (item.node_a == NODE_W'(j))
            begin
                pkt_a = state_reg[j*PKT_W +: PKT_W];
            end
            if (item.node_b == NODE_W'(j))
            begin
                pkt_b = state_reg[j*PKT_W +: PKT_W];
            end
        end
        for (int i = 0; i < NODES; i++)
        begin
            if (item.action == ACT_LOAD)
            begin
                state_next[i*PKT_W +: PKT_W] = item.load_word[i*PKT_W +: PKT_W];
            end
            else if (swap_ok && item.node_a == NODE_W'(i))
            begin
                state_next[i*PKT_W +: PKT_W] = pkt_b;
            end
            else if (swap_ok && item.node_b == NODE_W'(i))
            begin
                state_next[i*PKT_W +: PKT_W] = pkt_a;
            end
            else
            begin
                state_next[i*PKT_W +: PKT_W] = state_reg[i*PKT_W +: PKT_W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                state_reg[i*PKT_W +: PKT_W] <= PKT_W'(i);
            end
        end
        else if (load_en)
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hw/rtl/hps_score.sv]
// ---------------------------------------------------------------------------
// hps_score
// Per-node distance scoring and result word assembly.
// ---------------------------------------------------------------------------
module hps_score import hps_pkg::*; (
    input  hps_item_t          item,
    input  logic [STATE_W-1:0] state,
    output hps_result_t        result
);

    logic [NODE_W-1:0] pair_x;

    always_comb
    begin
        logic [PKT_W-1:0]  p;
        logic [NODE_W-1:0] diff;
        logic [1:0]        d;
        logic [4:0]        dsum;
        logic [3:0]        mis;
        logic [1:0]        worst;
        logic [4:0]        score [NUM_DIMS];

        result = '0;
        dsum   = '0;
        mis    = '0;
        worst  = '0;
        for (int k = 0; k < NUM_DIMS; k++)
        begin
            score[k] = '0;
        end
        for (int i = 0; i < NODES; i++)
        begin
            p    = state[i*PKT_W +: PKT_W];
            diff = (NODE_W'(i) ^ p[NODE_W-1:0]) & DIM_MASK;
            d    = 2'(diff[0]) + 2'(diff[1]) + 2'(diff[2]);
            result.packed_state[i*PKT_W +: PKT_W] = p;
            if (p != PKT_W'(i))
            begin
                mis = mis + 4'd1;
            end
            dsum = dsum + 5'(d);
            if (d > worst)
            begin
                worst = d;
            end
            for (int k = 0; k < NUM_DIMS; k++)
            begin
                if (diff[k])
                begin
                    score[k] = score[k] + 5'(d);
                end
            end
        end
        pair_x                = item.node_a ^ item.node_b;
        result.solved         = (mis == 4'd0);
        result.distance_sum   = dsum;
        result.misplaced      = mis;
        result.worst_distance = worst;
        result.dim0_score     = score[0];
        result.dim1_score     = score[1];
        result.dim2_score     = score[2];
        result.pair_is_edge   = (item.action == ACT_SWAP)
                                && (pair_x != '0)
                                && ((pair_x & (pair_x - NODE_W'(1))) == '0);
    end

endmodule

[hw/rtl/hypercube_permutation_scorer_top.sv]
// ---------------------------------------------------------------------------
// hypercube_permutation_scorer_top
// State update and scoring are combinational; the output register holds the result.
// Throughput: 1 word per cycle unless result_ready holds off a full output.
// Reset: node registers return to identity, output register empties.
// Load or swap the node packets and return state plus distance scores.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hypercube_permutation_scorer_top import hps_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  hps_item_t   item,
    output logic        result_valid,
    input  logic        result_ready,
    output hps_result_t result
);

    logic               accept;
    logic [STATE_W-1:0] state_next;
    hps_result_t        score_next;
    hps_result_t        result_reg;
    logic               valid_reg;
    logic               valid_next;

    assign item_ready   = !valid_reg || result_ready;
    assign accept       = item_valid && item_ready;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    hps_state u_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (accept),
        .item       (item),
        .state_next (state_next)
    );

    hps_score u_score (
        .item   (item),
        .state  (state_next),
        .result (score_next)
    );

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= score_next;
        end
    end

    `HPS_ASSERT_NXT(a_accept_fills, accept, result_valid, "accepted word left no result")
    `HPS_ASSERT_IMP(a_solved_zero, result_valid && result.solved,
        result.distance_sum == 5'd0 && result.misplaced == 4'd0, "solved with nonzero score")
    `HPS_ASSERT_IMP(a_worst_zero, result_valid && result.worst_distance == 2'd0,
        result.distance_sum == 5'd0 && result.dim0_score == 5'd0
        && result.dim1_score == 5'd0 && result.dim2_score == 5'd0,
        "zero worst distance with nonzero sums")

endmodule

[dv/hps_score_checker.sv]
// ---------------------------------------------------------------------------
// hps_score_checker
// Watches both channels of the hypercube permutation scorer. It keeps its
// own copy of the node packets, scores every accepted input word and queues
// the expected result. Each accepted result word is checked field by field
// against the oldest queued score.
// ---------------------------------------------------------------------------
module hps_score_checker import hps_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  hps_item_t   item,
    input  logic        result_valid,
    input  logic        result_ready,
    input  hps_result_t result,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PKT_W-1:0] node_pkt [NODES];
    hps_result_t      expected_scores [$];

    task automatic flag_error(input string msg);
        $display("%0t checker: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic score_action(input hps_item_t w, output hps_result_t r);
        logic [NODE_W-1:0] pair_diff;
        logic [PKT_W-1:0]  held;
        logic [PKT_W-1:0]  swap_tmp;
        logic [NODE_W-1:0] bit_diff;
        int                node_dist;
        int                dist_total;
        int                wrong_nodes;
        int                max_dist;
        int                dim_total [NUM_DIMS];
        r = '0;
        dist_total = 0;
        wrong_nodes = 0;
        max_dist = 0;
        for (int k = 0; k < NUM_DIMS; k++)
            dim_total[k] = 0;
        if (w.action == ACT_LOAD)
        begin
            for (int i = 0; i < NODES; i++)
                node_pkt[i] = w.load_word[PKT_W*i +: PKT_W];
        end
        else
        begin
            pair_diff = w.node_a ^ w.node_b;
            r.pair_is_edge = (pair_diff != '0) && ((pair_diff & (pair_diff - 1'b1)) == '0);
            if ({1'b0, w.node_a} < NODES_CNT && {1'b0, w.node_b} < NODES_CNT)
            begin
                swap_tmp = node_pkt[w.node_a];
                node_pkt[w.node_a] = node_pkt[w.node_b];
                node_pkt[w.node_b] = swap_tmp;
            end
        end
        r.solved = 1'b1;
        for (int i = 0; i < NODES; i++)
        begin
            held = node_pkt[i];
            bit_diff = (NODE_W'(i) ^ held[NODE_W-1:0]) & DIM_MASK;
            node_dist = $countones(bit_diff);
            r.packed_state[PKT_W*i +: PKT_W] = held;
            if (held != PKT_W'(i))
            begin
                r.solved = 1'b0;
                wrong_nodes++;
            end
            dist_total += node_dist;
            if (node_dist > max_dist)
                max_dist = node_dist;
            for (int k = 0; k < NUM_DIMS; k++)
                if (k < DIMS && bit_diff[k])
                    dim_total[k] += node_dist;
        end
        r.distance_sum   = 5'(dist_total);
        r.misplaced      = 4'(wrong_nodes);
        r.worst_distance = 2'(max_dist);
        r.dim0_score     = 5'(dim_total[0]);
        r.dim1_score     = 5'(dim_total[1]);
        r.dim2_score     = 5'(dim_total[2]);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        hps_result_t want;
        hps_result_t fresh;
        if (!rst_n)
        begin
            for (int i = 0; i < NODES; i++)
                node_pkt[i] = PKT_W'(i);
            expected_scores.delete();
            pending <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_scores.size() == 0)
                    flag_error($sformatf("result word 0x%0h with nothing expected", result));
                else
                begin
                    want = expected_scores.pop_front();
                    check_field("packed_state", result.packed_state, want.packed_state);
                    check_field("solved", result.solved, want.solved);
                    check_field("distance_sum", result.distance_sum, want.distance_sum);
                    check_field("misplaced", result.misplaced, want.misplaced);
                    check_field("worst_distance", result.worst_distance,
                                want.worst_distance);
                    check_field("dim0_score", result.dim0_score, want.dim0_score);
                    check_field("dim1_score", result.dim1_score, want.dim1_score);
                    check_field("dim2_score", result.dim2_score, want.dim2_score);
                    check_field("pair_is_edge", result.pair_is_edge, want.pair_is_edge);
                end
            end
            if (item_valid && item_ready)
            begin
                score_action(item, fresh);
                expected_scores = {expected_scores, fresh};
            end
            pending <= expected_scores.size();
        end
    end

endmodule

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Drives load and swap words into the hypercube permutation scorer: a short
// directed set of corner states and swaps, then random permutations, raw
// loads and mostly edge swaps, with random idling on both channels and one
// long receiver hold-off. The checker scores every word; the top decides.
// ---------------------------------------------------------------------------
module testbench import hps_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS  = 1100;
    localparam int HOLD_START    = 600;
    localparam int HOLD_LEN      = 150;
    localparam int RX_STEADY_LO  = 1500;
    localparam int RX_STEADY_HI  = 1900;
    localparam int TX_STEADY_LO  = 500;
    localparam int TX_STEADY_HI  = 700;
    localparam int CYCLE_LIMIT   = 100000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        result_ready = 1'b0;
    hps_item_t   item = '0;
    logic        item_ready;
    logic        result_valid;
    hps_result_t result;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;

    always #5 clk = ~clk;

    hypercube_permutation_scorer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    hps_score_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // hold off the result side once, then run steady, otherwise idle at random
    always @(posedge clk)
    begin
        if (cycle_count >= HOLD_START && cycle_count < HOLD_START + HOLD_LEN)
            result_ready <= 1'b0;
        else if (cycle_count >= RX_STEADY_LO && cycle_count < RX_STEADY_HI)
            result_ready <= 1'b1;
        else
            result_ready <= ($urandom_range(0, 99) >= 31);
    end

    function automatic hps_item_t make_load(input logic [WORD_W-1:0] word);
        hps_item_t w;
        w.action    = ACT_LOAD;
        w.load_word = word;
        w.node_a    = NODE_W'($urandom_range(0, 7));
        w.node_b    = NODE_W'($urandom_range(0, 7));
        return w;
    endfunction

    function automatic hps_item_t make_swap(input int a, input int b);
        hps_item_t w;
        w.action    = ACT_SWAP;
        w.load_word = $urandom;
        w.node_a    = NODE_W'(a);
        w.node_b    = NODE_W'(b);
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] shuffled_word();
        int                perm [NODES];
        int                j;
        int                tmp;
        logic [WORD_W-1:0] word;
        word = '0;
        for (int i = 0; i < NODES; i++)
            perm[i] = i;
        for (int i = NODES - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < NODES; i++)
            word[PKT_W*i +: PKT_W] = PKT_W'(perm[i]);
        return word;
    endfunction

    function automatic hps_item_t random_action();
        int pick;
        int a;
        pick = $urandom_range(0, 99);
        a = $urandom_range(0, NODES - 1);
        if (pick < 10)
            return make_load(shuffled_word());
        else if (pick < 18)
            return make_load($urandom);
        else if (pick < 20)
            return make_load(32'h7654_3210);
        else if (pick < 70)
            return make_swap(a, a ^ (1 << $urandom_range(0, DIMS - 1)));
        else if (pick < 92)
            return make_swap(a, $urandom_range(0, NODES - 1));
        else
            return make_swap(a, a);
    endfunction

    task automatic offer_word(input hps_item_t w, input bit steady);
        if (!steady && $urandom_range(0, 99) < 31)
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < 31);
        end
        item_valid <= 1'b1;
        item <= w;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_word(make_swap(0, 1), 1'b0);
        offer_word(make_load(32'h7654_3210), 1'b0);
        offer_word(make_load(32'h0000_0000), 1'b0);
        offer_word(make_load(32'hFFFF_FFFF), 1'b0);
        offer_word(make_load(32'hFEDC_BA98), 1'b0);
        offer_word(make_load(32'h0123_4567), 1'b0);
        offer_word(make_swap(7, 0), 1'b0);
        offer_word(make_load(32'h7654_3210), 1'b0);
        offer_word(make_swap(0, 1), 1'b0);
        offer_word(make_swap(2, 6), 1'b0);
        offer_word(make_swap(0, 4), 1'b0);
        offer_word(make_swap(3, 7), 1'b0);
        offer_word(make_swap(5, 5), 1'b0);
        offer_word(make_swap(0, 3), 1'b0);
        offer_word(make_swap(1, 6), 1'b0);
        offer_word(make_swap(6, 1), 1'b0);
        offer_word(make_swap(3, 0), 1'b0);
        offer_word(make_load(32'h8765_4321), 1'b0);
        offer_word(make_load(shuffled_word()), 1'b0);
        offer_word(make_swap(4, 5), 1'b0);

        for (int n = 0; n < RANDOM_WORDS; n++)
            offer_word(random_action(), n >= TX_STEADY_LO && n < TX_STEADY_HI);
        item_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
